// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define RMT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define RMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rmt_pkg.sv =====
// Shared constants, types and helpers of the regret-matching table.
// No dependencies.
package rmt_pkg;

  localparam int NumSets    = 256;
  localparam int MaxActions = 4;
  localparam int SetW       = 8;
  localparam int ActW       = 2;
  localparam int AddrW      = SetW + ActW;
  localparam int Depth      = NumSets * MaxActions;
  localparam int SumW       = 32;
  localparam int ProbW      = 17;
  localparam int CfgW       = 19;
  localparam int IterW      = 20;
  localparam int ReachW     = 17;
  localparam int UtilW      = 32;
  localparam int RemW       = 35;
  localparam int TotalW     = 34;

  localparam logic [CfgW-1:0] RegretDiscRst = 19'd43691;
  localparam logic [CfgW-1:0] StratDiscRst  = 19'd131072;

  typedef enum logic [1:0] {
    FUNC_CUR  = 2'd0,
    FUNC_AVG  = 2'd1,
    FUNC_UPD  = 2'd2,
    FUNC_DISC = 2'd3
  } func_e;

  typedef enum logic {
    REG_REGRET_DISC = 1'b0,
    REG_STRAT_DISC  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [SumW-1:0]  data;
  } mem_wr_t;

  function automatic logic [ProbW-1:0] uniform_prob(input logic [2:0] cnt);
    logic [ProbW-1:0] p;
    case (cnt)
      3'd1:    p = 17'd65536;
      3'd2:    p = 17'd32768;
      3'd3:    p = 17'd21845;
      3'd4:    p = 17'd16384;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [SumW-1:0] sat_sum(input logic [RemW-1:0] v);
    return (|v[RemW-1:SumW]) ? {SumW{1'b1}} : v[SumW-1:0];
  endfunction

endpackage

// ===== rtl/regret_matching_table_unit.sv =====
// Regret-matching table: command sequencer around the sum memories and divider.
// Depends on rmt_pkg, rmt_store, rmt_div.
//
// After reset the block clears both memories, one entry per cycle (busy high).
// A command is taken when start is high and busy low. Queries read the four
// entries of a set and sum them. With a nonzero sum each legal action then goes
// through the 17-step serial divider; otherwise each legal action gets the uniform
// probability, and other actions always get zero. Queries then emit one result per
// legal action. An update skips the emit: it computes the node utility, writes back
// the regret and strategy sums of each legal action and gives a single result. A
// discount sweeps all 1024 entries through the memory port and holds busy until the
// sweep is done. A query or update with an empty mask goes straight to its single
// result. Results come on result_valid_o and cannot be held off.
module regret_matching_table_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [rmt_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 func_i,
  input  logic [rmt_pkg::SetW-1:0]   set_index_i,
  input  logic [3:0]                 legal_mask_i,
  input  logic signed [31:0]         utility_a0_i,
  input  logic signed [31:0]         utility_a1_i,
  input  logic signed [31:0]         utility_a2_i,
  input  logic signed [31:0]         utility_a3_i,
  input  logic [rmt_pkg::ReachW-1:0] reach_weight_i,
  input  logic [rmt_pkg::IterW-1:0]  iteration_i,
  output logic                       result_valid_o,
  output logic [1:0]                 result_action_o,
  output logic [rmt_pkg::ProbW-1:0]  result_probability_o,
  output logic signed [31:0]         result_value_o,
  output logic                       result_last_o
);
  import rmt_pkg::*;

  typedef enum logic [14:0] {
    S_CLR  = 15'b000000000000001,
    S_IDLE = 15'b000000000000010,
    S_RD   = 15'b000000000000100,
    S_SUM  = 15'b000000000001000,
    S_DIV  = 15'b000000000010000,
    S_DIVW = 15'b000000000100000,
    S_EMIT = 15'b000000001000000,
    S_NMUL = 15'b000000010000000,
    S_NACC = 15'b000000100000000,
    S_NFIN = 15'b000001000000000,
    S_UMUL = 15'b000010000000000,
    S_UREG = 15'b000100000000000,
    S_USTR = 15'b001000000000000,
    S_DISC = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [CfgW-1:0]   rdisc_q, sdisc_q;
  func_e             func_q;
  logic [SetW-1:0]   set_q;
  logic [3:0]        mask_q;
  logic signed [UtilW-1:0] util_q [MaxActions];
  logic [ReachW-1:0] reach_q;
  logic [IterW-1:0]  iter_q;

  logic [SumW-1:0]   rrow_q [MaxActions];
  logic [SumW-1:0]   srow_q [MaxActions];
  logic [ProbW-1:0]  prob_q [MaxActions];
  logic [ActW-1:0]   a_q;
  logic [2:0]        step_q;
  logic [TotalW-1:0] total_q;
  logic signed [49:0] nprod_q;
  logic signed [51:0] acc_q;
  logic signed [31:0] node_q;
  logic signed [50:0] rprod_q;
  logic [36:0]       sprod_q;

  logic [AddrW-1:0]  cnt_q, a1_q, a2_q;
  logic              issue_q, v1_q, v2_q;
  logic [SumW-1:0]   dr_q, ds_q;

  logic              rd_en, div_start, div_done, legal, last_a;
  logic [AddrW-1:0]  rd_addr, row_addr;
  mem_wr_t           wr_regret, wr_strat;
  logic [SumW-1:0]   mem_r, mem_s, src;
  logic [RemW-1:0]   div_rem0, div_den;
  logic [ProbW-1:0]  div_low, quot;
  logic [2:0]        count;
  logic [3:0]        mask_hi;
  logic signed [35:0] node_sh;
  logic signed [31:0] node_sat;
  logic signed [32:0] diff;
  logic signed [34:0] delta;
  logic signed [35:0] rsum;
  logic [SumW-1:0]   new_regret;
  logic [50:0]       dmul_r, dmul_s;

  assign busy     = state_q != S_IDLE;
  assign row_addr = {set_q, a_q};
  assign legal    = mask_q[a_q];
  assign last_a   = a_q == ActW'(MaxActions - 1);
  assign src      = (func_q == FUNC_AVG) ? srow_q[a_q] : rrow_q[a_q];
  assign count    = 3'(mask_q[0]) + 3'(mask_q[1]) + 3'(mask_q[2]) + 3'(mask_q[3]);
  assign mask_hi  = mask_q >> a_q;

  assign node_sh  = acc_q[51:16];
  assign node_sat = (node_sh[35:31] == 5'b00000 || node_sh[35:31] == 5'b11111) ?
                    node_sh[31:0] : (node_sh[35] ? 32'sh80000000 : 32'sh7FFFFFFF);
  assign diff     = $signed({util_q[a_q][31], util_q[a_q]}) - $signed({node_q[31], node_q});
  assign delta    = rprod_q[50:16];
  assign rsum     = $signed({4'b0, rrow_q[a_q]}) + $signed({delta[34], delta});
  assign new_regret = rsum[35] ? '0 : sat_sum(rsum[34:0]);

  assign dmul_r = mem_r * rdisc_q;
  assign dmul_s = mem_s * sdisc_q;

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = row_addr;
    div_start = 1'b0;
    div_rem0 = {4'b0, src[SumW-1:1]};
    div_low  = {src[0], 16'b0};
    div_den  = {1'b0, total_q};
    wr_regret = '{we: 1'b0, addr: row_addr, data: new_regret};
    wr_strat  = '{we: 1'b0, addr: row_addr,
                  data: sat_sum(RemW'({1'b0, srow_q[a_q]} + 33'(quot)))};
    unique case (state_q)
      S_CLR: begin
        wr_regret = '{we: 1'b1, addr: cnt_q, data: '0};
        wr_strat  = '{we: 1'b1, addr: cnt_q, data: '0};
      end
      S_RD: begin
        rd_en   = step_q < 3'(MaxActions);
        rd_addr = {set_q, step_q[ActW-1:0]};
      end
      S_DIV: div_start = legal && (total_q != '0);
      S_UREG: begin
        wr_regret.we = 1'b1;
        div_start = 1'b1;
        div_rem0  = RemW'(sprod_q[36:17]);
        div_low   = sprod_q[16:0];
        div_den   = RemW'({1'b0, iter_q} + 21'd1);
      end
      S_USTR: wr_strat.we = div_done;
      S_DISC: begin
        rd_en     = issue_q;
        rd_addr   = cnt_q;
        wr_regret = '{we: v2_q, addr: a2_q, data: dr_q};
        wr_strat  = '{we: v2_q, addr: a2_q, data: ds_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (cnt_q == AddrW'(Depth - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (func_e'(func_i) == FUNC_DISC) state_d = S_DISC;
          else if (legal_mask_i == '0)     state_d = S_OUT;
          else                             state_d = S_RD;
        end
      end
      S_RD:   if (step_q == 3'(MaxActions)) state_d = S_SUM;
      S_SUM:  if (last_a) state_d = S_DIV;
      S_DIV: begin
        if (div_start) state_d = S_DIVW;
        else if (last_a) state_d = (func_q == FUNC_UPD) ? S_NMUL : S_EMIT;
      end
      S_DIVW: begin
        if (div_done) begin
          if (!last_a) state_d = S_DIV;
          else         state_d = (func_q == FUNC_UPD) ? S_NMUL : S_EMIT;
        end
      end
      S_EMIT: if (last_a) state_d = S_IDLE;
      S_NMUL: state_d = S_NACC;
      S_NACC: state_d = last_a ? S_NFIN : S_NMUL;
      S_NFIN: state_d = S_UMUL;
      S_UMUL: begin
        if (legal) state_d = S_UREG;
        else if (last_a) state_d = S_OUT;
      end
      S_UREG: state_d = S_USTR;
      S_USTR: if (div_done) state_d = last_a ? S_OUT : S_UMUL;
      S_DISC: if (!issue_q && !v1_q && !v2_q) state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      cnt_q          <= '0;
      rdisc_q        <= RegretDiscRst;
      sdisc_q        <= StratDiscRst;
      result_valid_o <= 1'b0;
      issue_q        <= 1'b0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_reg_e'(cfg_index_i) == REG_REGRET_DISC) rdisc_q <= cfg_data_i;
        else                                            sdisc_q <= cfg_data_i;
      end
      if (state_q == S_CLR) cnt_q <= cnt_q + AddrW'(1);
      if (state_q == S_IDLE && start) begin
        cnt_q   <= '0;
        issue_q <= 1'b1;
        v1_q    <= 1'b0;
        v2_q    <= 1'b0;
      end
      if (state_q == S_DISC) begin
        v1_q <= issue_q;
        v2_q <= v1_q;
        if (issue_q) begin
          if (cnt_q == AddrW'(Depth - 1)) issue_q <= 1'b0;
          else                            cnt_q   <= cnt_q + AddrW'(1);
        end
      end
      if (state_q == S_EMIT) result_valid_o <= legal;
      if (state_q == S_OUT)  result_valid_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        func_q    <= func_e'(func_i);
        set_q     <= set_index_i;
        mask_q    <= legal_mask_i;
        util_q[0] <= utility_a0_i;
        util_q[1] <= utility_a1_i;
        util_q[2] <= utility_a2_i;
        util_q[3] <= utility_a3_i;
        reach_q   <= reach_weight_i;
        iter_q    <= iteration_i;
        node_q    <= '0;
        acc_q     <= '0;
        total_q   <= '0;
        a_q       <= '0;
        step_q    <= '0;
      end
      S_RD: begin
        step_q <= step_q + 3'd1;
        if (step_q != 3'd0) begin
          rrow_q[ActW'(step_q - 3'd1)] <= mem_r;
          srow_q[ActW'(step_q - 3'd1)] <= mem_s;
        end
      end
      S_SUM: begin
        if (legal) total_q <= total_q + TotalW'(src);
        a_q <= a_q + ActW'(1);
      end
      S_DIV: begin
        if (!div_start) begin
          prob_q[a_q] <= legal ? uniform_prob(count) : '0;
          a_q <= a_q + ActW'(1);
        end
      end
      S_DIVW: begin
        if (div_done) begin
          prob_q[a_q] <= quot;
          a_q <= a_q + ActW'(1);
        end
      end
      S_EMIT: begin
        result_action_o      <= a_q;
        result_probability_o <= prob_q[a_q];
        result_value_o       <= '0;
        result_last_o        <= mask_hi[3:1] == 3'b000;
        a_q <= a_q + ActW'(1);
      end
      S_NMUL: nprod_q <= legal ? $signed({1'b0, prob_q[a_q]}) * util_q[a_q] : 50'sd0;
      S_NACC: begin
        acc_q <= acc_q + {{2{nprod_q[49]}}, nprod_q};
        a_q   <= a_q + ActW'(1);
      end
      S_NFIN: node_q <= node_sat;
      S_UMUL: begin
        rprod_q <= diff * $signed({1'b0, reach_q});
        sprod_q <= prob_q[a_q] * iter_q;
        if (!legal) a_q <= a_q + ActW'(1);
      end
      S_USTR: if (div_done) a_q <= a_q + ActW'(1);
      S_DISC: begin
        a1_q <= cnt_q;
        a2_q <= a1_q;
        dr_q <= sat_sum(dmul_r[50:16]);
        ds_q <= sat_sum(dmul_s[50:16]);
      end
      S_OUT: begin
        result_action_o      <= '0;
        result_probability_o <= '0;
        result_value_o       <= node_q;
        result_last_o        <= 1'b1;
      end
      default: ;
    endcase
  end

  rmt_store u_store (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .wr_regret_i (wr_regret),
    .wr_strat_i  (wr_strat),
    .regret_o    (mem_r),
    .strat_o     (mem_s)
  );

  rmt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem0_i  (div_rem0),
    .low_i   (div_low),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );
endmodule

// ===== rtl/rmt_div.sv =====
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// Depends on rmt_pkg.
module rmt_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rmt_pkg::RemW-1:0]  rem0_i,
  input  logic [rmt_pkg::ProbW-1:0] low_i,
  input  logic [rmt_pkg::RemW-1:0]  den_i,
  output logic                      done_o,
  output logic [rmt_pkg::ProbW-1:0] quot_o
);
  import rmt_pkg::*;

  logic [RemW-1:0]  rem_q, den_q;
  logic [ProbW-1:0] low_q, quot_q;
  logic [4:0]       cnt_q;
  logic             run_q, done_q;
  logic [RemW:0]    sh;
  logic             ge;

  assign sh = {rem_q, low_q[ProbW-1]};
  assign ge = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(ProbW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem0_i;
      low_q <= low_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q  <= ge ? RemW'(sh - {1'b0, den_q}) : sh[RemW-1:0];
      low_q  <= {low_q[ProbW-2:0], 1'b0};
      quot_q <= {quot_q[ProbW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// ===== rtl/rmt_store.sv =====
// Regret and strategy sum memories, one read port and one write port each.
// Depends on rmt_pkg.
module rmt_store (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [rmt_pkg::AddrW-1:0] rd_addr_i,
  input  rmt_pkg::mem_wr_t          wr_regret_i,
  input  rmt_pkg::mem_wr_t          wr_strat_i,
  output logic [rmt_pkg::SumW-1:0]  regret_o,
  output logic [rmt_pkg::SumW-1:0]  strat_o
);
  import rmt_pkg::*;

  logic [SumW-1:0] regret_mem [Depth];
  logic [SumW-1:0] strat_mem  [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_regret_i.we) begin
      regret_mem[wr_regret_i.addr] <= wr_regret_i.data;
    end
    if (rd_en_i) begin
      regret_o <= regret_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_strat_i.we) begin
      strat_mem[wr_strat_i.addr] <= wr_strat_i.data;
    end
    if (rd_en_i) begin
      strat_o <= strat_mem[rd_addr_i];
    end
  end
endmodule

// ===== rtl/rmt_checker.sv =====
// Port-level checks of the regret-matching table, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [16:0] result_probability_o,
  input logic [31:0] result_value_o,
  input logic        result_last_o
);
  `RMT_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "not busy")
  `RMT_ASSERT(a_mid_busy, clk_i, rst_ni, (result_valid_o && !result_last_o) |-> busy, "idle")
  `RMT_ASSERT(a_value_last, clk_i, rst_ni, (result_valid_o && result_value_o != 0) |-> (result_last_o && result_probability_o == 0), "value")
  `RMT_ASSERT(a_prob_range, clk_i, rst_ni, (result_valid_o && result_probability_o[16]) |-> (result_probability_o[15:0] == 0), "prob")
  `RMT_ASSERT_ALWAYS(a_rst_quiet, clk_i, (!rst_ni ##1 !rst_ni) |-> (busy && !result_valid_o), "reset")
endmodule

bind regret_matching_table_unit rmt_checker u_rmt_checker (.*);
